/* rtl/complex_integer_alu_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the complex integer ALU
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_ALU_MACROS_SVH
`define COMPLEX_INTEGER_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CIA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define CIA_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Widths, command codes and request/response types of the complex ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int CIA_WIDTH = 16;
    // Products, numerators and the squared magnitude need twice the width.
    localparam int CIA_NW    = 2 * CIA_WIDTH;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;
    localparam logic [2:0] CMD_NEG  = 3'd5;
    localparam logic [2:0] CMD_EQ   = 3'd6;

    typedef struct packed {
        logic [2:0]                  command;
        logic signed [CIA_WIDTH-1:0] a_re;
        logic signed [CIA_WIDTH-1:0] a_im;
        logic signed [CIA_WIDTH-1:0] b_re;
        logic signed [CIA_WIDTH-1:0] b_im;
    } cia_req_t;

    typedef struct packed {
        logic signed [CIA_WIDTH-1:0] res_re;
        logic signed [CIA_WIDTH-1:0] res_im;
        logic                        is_equal;
        logic                        div_by_zero;
    } cia_rsp_t;

    // Everything an item carries alongside the divider.
    typedef struct packed {
        logic                 is_div;
        logic                 neg_re;
        logic                 neg_im;
        logic                 div_by_zero;
        logic                 is_equal;
        logic [CIA_WIDTH-1:0] res_re;
        logic [CIA_WIDTH-1:0] res_im;
    } cia_side_t;

endpackage

/* rtl/cia_div_step.sv */
// ----------------------------------------------------------------------------
// cia_div_step
// One registered restoring-division step: produces one quotient bit.
// ----------------------------------------------------------------------------
module cia_div_step import cia_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [CIA_NW-1:0] rem_i,
    input  logic [CIA_NW-1:0] num_i,
    input  logic [CIA_NW-1:0] q_i,
    input  logic [CIA_NW-1:0] den_i,
    output logic [CIA_NW-1:0] rem_o,
    output logic [CIA_NW-1:0] num_o,
    output logic [CIA_NW-1:0] q_o
);

    logic [CIA_NW-1:0] rem_reg, num_reg, q_reg;
    logic [CIA_NW-1:0] rem_next, num_next, q_next;
    logic [CIA_NW:0]   trial;
    logic [CIA_NW:0]   diff;
    logic              fits;

    always_comb begin
        // Bring down the next numerator bit and try to subtract the divisor.
        trial    = {rem_i, num_i[CIA_NW-1]};
        diff     = trial - {1'b0, den_i};
        fits     = (trial >= {1'b0, den_i});
        rem_next = fits ? diff[CIA_NW-1:0] : trial[CIA_NW-1:0];
        num_next = {num_i[CIA_NW-2:0], 1'b0};
        q_next   = {q_i[CIA_NW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    assign rem_o = rem_reg;
    assign num_o = num_reg;
    assign q_o   = q_reg;

endmodule

/* rtl/complex_integer_alu.sv */
// ----------------------------------------------------------------------------
// complex_integer_alu
// Pipelined complex-number ALU: add, subtract, multiply, divide, conjugate,
// negate and equality compare over 16-bit signed parts.
// ----------------------------------------------------------------------------
// The unit accepts one request per clock while the output is not stalled
// and returns one response per request, in order, through the pipe:
// one stage of multipliers, one stage of sums, one stage that takes the
// numerator magnitudes, 32 divider stages that each produce one quotient
// bit, and the output register. The divider depth sets the latency; every
// command travels the same path, so responses never reorder. The whole pipe
// advances together whenever the output register is empty or being taken,
// so s_ready follows m_ready and a stall loses and repeats nothing. Sums,
// differences and products wrap to 16 bits. Division forms
// (a * conj(b)) / |b|^2 at full precision, truncates toward zero and wraps;
// a zero divisor returns zero with div_by_zero set. Command code 7 returns
// all zeros.
// ----------------------------------------------------------------------------
module complex_integer_alu import cia_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cia_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output cia_rsp_t m_rsp
);

    localparam int W  = CIA_WIDTH;
    localparam int NW = CIA_NW;

    // Global advance: the pipe moves when the output slot is free or taken.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: operands and all partial products.
    // ------------------------------------------------------------------
    logic                  v1_reg;
    cia_req_t              req1_reg;
    logic signed [NW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [NW-1:0]  p_bb_reg, p_cc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            req1_reg <= s_req;
            p_rr_reg <= s_req.a_re * s_req.b_re;
            p_ii_reg <= s_req.a_im * s_req.b_im;
            p_ri_reg <= s_req.a_re * s_req.b_im;
            p_ir_reg <= s_req.a_im * s_req.b_re;
            p_bb_reg <= s_req.b_re * s_req.b_re;
            p_cc_reg <= s_req.b_im * s_req.b_im;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: simple results, numerators and squared magnitude.
    // ------------------------------------------------------------------
    logic                 v2_reg;
    cia_side_t            side2_reg, side2_next;
    logic signed [NW:0]   nr2_reg, ni2_reg;
    logic [NW-1:0]        den2_reg;

    always_comb begin
        side2_next = '0;
        case (req1_reg.command)
            CMD_ADD: begin
                side2_next.res_re = req1_reg.a_re + req1_reg.b_re;
                side2_next.res_im = req1_reg.a_im + req1_reg.b_im;
            end
            CMD_SUB: begin
                side2_next.res_re = req1_reg.a_re - req1_reg.b_re;
                side2_next.res_im = req1_reg.a_im - req1_reg.b_im;
            end
            CMD_MUL: begin
                side2_next.res_re = p_rr_reg[W-1:0] - p_ii_reg[W-1:0];
                side2_next.res_im = p_ri_reg[W-1:0] + p_ir_reg[W-1:0];
            end
            CMD_DIV: begin
                side2_next.is_div      = 1'b1;
                side2_next.div_by_zero = (req1_reg.b_re == '0) && (req1_reg.b_im == '0);
            end
            CMD_CONJ: begin
                side2_next.res_re = req1_reg.a_re;
                side2_next.res_im = -req1_reg.a_im;
            end
            CMD_NEG: begin
                side2_next.res_re = -req1_reg.a_re;
                side2_next.res_im = -req1_reg.a_im;
            end
            CMD_EQ: begin
                side2_next.is_equal = (req1_reg.a_re == req1_reg.b_re) &&
                                      (req1_reg.a_im == req1_reg.b_im);
            end
            default: begin
                side2_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            nr2_reg   <= {p_rr_reg[NW-1], p_rr_reg} + {p_ii_reg[NW-1], p_ii_reg};
            ni2_reg   <= {p_ir_reg[NW-1], p_ir_reg} - {p_ri_reg[NW-1], p_ri_reg};
            den2_reg  <= p_bb_reg + p_cc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sign and magnitude of the numerators.
    // ------------------------------------------------------------------
    logic               v3_reg;
    cia_side_t          side3_reg, side3_next;
    logic [NW-1:0]      mag_re_reg, mag_im_reg;
    logic [NW-1:0]      den3_reg;
    logic signed [NW:0] abs_re, abs_im;

    always_comb begin
        side3_next        = side2_reg;
        side3_next.neg_re = nr2_reg[NW];
        side3_next.neg_im = ni2_reg[NW];
        abs_re            = nr2_reg[NW] ? -nr2_reg : nr2_reg;
        abs_im            = ni2_reg[NW] ? -ni2_reg : ni2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg  <= side3_next;
            mag_re_reg <= abs_re[NW-1:0];
            mag_im_reg <= abs_im[NW-1:0];
            den3_reg   <= den2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: NW restoring steps, one quotient bit per stage, both lanes.
    // Index 0 of each array is the divider input.
    // ------------------------------------------------------------------
    logic [NW-1:0] rem_re [0:NW];
    logic [NW-1:0] num_re [0:NW];
    logic [NW-1:0] q_re   [0:NW];
    logic [NW-1:0] rem_im [0:NW];
    logic [NW-1:0] num_im [0:NW];
    logic [NW-1:0] q_im   [0:NW];
    logic [NW-1:0] den_d  [0:NW];
    cia_side_t     side_d [0:NW];
    logic          v_d    [0:NW];

    assign rem_re[0] = '0;
    assign num_re[0] = mag_re_reg;
    assign q_re[0]   = '0;
    assign rem_im[0] = '0;
    assign num_im[0] = mag_im_reg;
    assign q_im[0]   = '0;
    assign den_d[0]  = den3_reg;
    assign side_d[0] = side3_reg;
    assign v_d[0]    = v3_reg;

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic          v_reg;
        logic [NW-1:0] den_reg;
        cia_side_t     side_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_d[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg  <= den_d[k];
                side_reg <= side_d[k];
            end
        end

        assign v_d[k+1]    = v_reg;
        assign den_d[k+1]  = den_reg;
        assign side_d[k+1] = side_reg;

        cia_div_step u_re (
            .aclk  (aclk),
            .en    (en),
            .rem_i (rem_re[k]),
            .num_i (num_re[k]),
            .q_i   (q_re[k]),
            .den_i (den_d[k]),
            .rem_o (rem_re[k+1]),
            .num_o (num_re[k+1]),
            .q_o   (q_re[k+1])
        );

        cia_div_step u_im (
            .aclk  (aclk),
            .en    (en),
            .rem_i (rem_im[k]),
            .num_i (num_im[k]),
            .q_i   (q_im[k]),
            .den_i (den_d[k]),
            .rem_o (rem_im[k+1]),
            .num_o (num_im[k+1]),
            .q_o   (q_im[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: apply the quotient signs and pick the result.
    // Only the low W quotient bits survive the wrap.
    // ------------------------------------------------------------------
    logic          m_valid_reg;
    cia_rsp_t      rsp_reg, rsp_next;
    cia_side_t     side_o;
    logic [W-1:0]  qlo_re, qlo_im;

    always_comb begin
        side_o   = side_d[NW];
        qlo_re   = q_re[NW][W-1:0];
        qlo_im   = q_im[NW][W-1:0];
        rsp_next = '0;
        rsp_next.is_equal    = side_o.is_equal;
        rsp_next.div_by_zero = side_o.div_by_zero;
        if (side_o.is_div && !side_o.div_by_zero) begin
            rsp_next.res_re = side_o.neg_re ? -qlo_re : qlo_re;
            rsp_next.res_im = side_o.neg_im ? -qlo_im : qlo_im;
        end else begin
            rsp_next.res_re = side_o.res_re;
            rsp_next.res_im = side_o.res_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_d[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

/* rtl/cia_checker.sv */
// ----------------------------------------------------------------------------
// cia_checker
// Port-level assertions for the complex integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_integer_alu_macros.svh"

module cia_checker import cia_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input cia_req_t s_req,
    input logic     m_valid,
    input logic     m_ready,
    input cia_rsp_t m_rsp
);

    // A stalled response holds.
    `CIA_ASSERT_NEXT(a_rsp_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rsp), "response changed while stalled")

    // Reset empties the pipe.
    `CIA_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_valid, "response valid after reset")

    // The two flags belong to different commands.
    `CIA_ASSERT_NOW(a_flags_excl, aclk, aresetn, m_valid, !(m_rsp.is_equal && m_rsp.div_by_zero), "both flags set")

    // A zero divisor returns zero.
    `CIA_ASSERT_NOW(a_dz_zero, aclk, aresetn, m_valid && m_rsp.div_by_zero, (m_rsp.res_re == '0) && (m_rsp.res_im == '0), "nonzero result on zero divisor")

    // Input side must not be blocked while the output slot is free.
    `CIA_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

/* verif/complex_integer_alu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_integer_alu_checker
// Watches both channels of the complex ALU, predicts each response from its
// request and compares the two field by field, in order.
// ----------------------------------------------------------------------------
module complex_integer_alu_checker import cia_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  cia_req_t s_req,
    input  logic     m_valid,
    input  logic     m_ready,
    input  cia_rsp_t m_rsp,
    output int       fail_count,
    output int       pending
);

    cia_rsp_t expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    // Signed truncating division of a full-precision numerator, wrapped.
    function automatic logic [CIA_WIDTH-1:0] div_wrap(longint num, longint den);
        longint q;
        q = num / den;
        return q[CIA_WIDTH-1:0];
    endfunction

    function automatic cia_rsp_t predict_rsp(cia_req_t r);
        cia_rsp_t o;
        longint ar, ai, br, bi, den;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        o = '0;
        case (r.command)
            CMD_ADD: begin
                o.res_re = r.a_re + r.b_re;
                o.res_im = r.a_im + r.b_im;
            end
            CMD_SUB: begin
                o.res_re = r.a_re - r.b_re;
                o.res_im = r.a_im - r.b_im;
            end
            CMD_MUL: begin
                o.res_re = CIA_WIDTH'(ar * br - ai * bi);
                o.res_im = CIA_WIDTH'(ar * bi + ai * br);
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    o.div_by_zero = 1'b1;
                end else begin
                    o.res_re = div_wrap(ar * br + ai * bi, den);
                    o.res_im = div_wrap(ai * br - ar * bi, den);
                end
            end
            CMD_CONJ: begin
                o.res_re = r.a_re;
                o.res_im = -r.a_im;
            end
            CMD_NEG: begin
                o.res_re = -r.a_re;
                o.res_im = -r.a_im;
            end
            CMD_EQ: o.is_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        cia_rsp_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_rsp_q.push_back(predict_rsp(s_req));
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unexpected response", 1, 0);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (m_rsp.res_re !== want.res_re)
                        report_mismatch("res_re", m_rsp.res_re, want.res_re);
                    if (m_rsp.res_im !== want.res_im)
                        report_mismatch("res_im", m_rsp.res_im, want.res_im);
                    if (m_rsp.is_equal !== want.is_equal)
                        report_mismatch("is_equal", m_rsp.is_equal, want.is_equal);
                    if (m_rsp.div_by_zero !== want.div_by_zero)
                        report_mismatch("div_by_zero", m_rsp.div_by_zero,
                                        want.div_by_zero);
                end
            end
        end
    end

endmodule

/* verif/complex_integer_alu_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_integer_alu_test
// Drives directed and random requests into the complex ALU with random gaps
// and back-pressure; a checker instance predicts and compares the responses.
// ----------------------------------------------------------------------------
module complex_integer_alu_test import cia_pkg::*;;

    localparam int LATENCY   = 36;
    localparam int N_RANDOM  = 1300;
    localparam int IDLE_PCT  = 33;
    // No acceptance on either side for this long means the block is hung.
    localparam int WATCHDOG  = 5000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cia_req_t s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cia_rsp_t m_rsp;
    int       fail_count;
    int       pending;

    // The sender and receiver each move between phases; these flags tell
    // the receiver when to hold off and both sides when to stop idling altogether.
    logic     hold_off_req = 1'b0;
    logic     no_idle = 1'b0;
    int       quiet_cycles = 0;

    always #5 aclk = ~aclk;

    complex_integer_alu u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    complex_integer_alu_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Picks an operand part: often uniform, often an extreme, sometimes a small
    // value, so wraps and small exact quotients both show up.
    function automatic logic [CIA_WIDTH-1:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return CIA_WIDTH'($signed($urandom_range(0, 16)) - 8);
            default: return CIA_WIDTH'($urandom);
        endcase
    endfunction

    // Offers one request, holding it until it is accepted. Idles first at
    // random unless idling is switched off.
    task automatic send_request(logic [2:0] cmd, logic [CIA_WIDTH-1:0] are,
                                logic [CIA_WIDTH-1:0] aim, logic [CIA_WIDTH-1:0] bre,
                                logic [CIA_WIDTH-1:0] bim);
        cia_req_t r;
        r.command = cmd;
        r.a_re = are;
        r.a_im = aim;
        r.b_re = bre;
        r.b_im = bim;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_random();
        logic [2:0] cmd;
        logic [CIA_WIDTH-1:0] are, aim, bre, bim;
        cmd = 3'($urandom_range(0, 7));
        are = pick_part();
        aim = pick_part();
        // Equality and division need matching or zero b often enough.
        if (cmd == CMD_EQ && $urandom_range(0, 1)) begin
            bre = are;
            bim = $urandom_range(0, 1) ? aim : pick_part();
        end else if (cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
            bre = '0;
            bim = '0;
        end else begin
            bre = pick_part();
            bim = pick_part();
        end
        send_request(cmd, are, aim, bre, bim);
    endtask

    // Receiver: random stalls, a long hold-off when asked, none in the
    // no-idle stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_req) begin
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long back-pressure stretch, counted here while the sender keeps going.
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_off_req <= 1'b1;
        repeat (200) @(posedge aclk);
        hold_off_req <= 1'b0;
    end

    // Watchdog: counts cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: every command, the extremes, the zero divisor,
        // negation of the most negative value and the unused command code.
        send_request(CMD_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
        send_request(CMD_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_request(CMD_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
        send_request(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        send_request(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(CMD_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_request(CMD_MUL, 16'h0003, 16'h0004, 16'h0005, 16'hfffe);
        send_request(CMD_DIV, 16'h0064, 16'h0032, 16'h0000, 16'h0000);
        send_request(CMD_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_request(CMD_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        send_request(CMD_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
        send_request(CMD_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        send_request(CMD_DIV, 16'hfff9, 16'h0007, 16'h0002, 16'h0000);
        send_request(CMD_DIV, 16'h0005, 16'h0000, 16'h0001, 16'h0001);
        send_request(CMD_CONJ, 16'h8000, 16'h8000, 16'h1234, 16'h5678);
        send_request(CMD_CONJ, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_NEG, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
        send_request(CMD_NEG, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
        send_request(CMD_EQ, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(CMD_EQ, 16'h8000, 16'h7fff, 16'h8000, 16'h7ffe);
        send_request(CMD_EQ, 16'h1234, 16'h5678, 16'h1235, 16'h5678);
        send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        // Random part, with a stretch in the middle where neither side idles.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 700)
                no_idle <= 1'b1;
            else if (i == 900)
                no_idle <= 1'b0;
            send_random();
        end
        s_valid <= 1'b0;

        // Drain; the watchdog covers a response that never comes.
        while (pending != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
